/* rtl/core/ilm_pkg.sv */
// Shared types and constants for the isoline level marker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ilm_pkg;

	// Q16.8 level and mark values
	localparam int MARK_W = 24;
	localparam int FRAC_BITS = 8;
	typedef logic signed [MARK_W-1:0] mark_t;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int WIDTH_REG_W = 13;
	localparam int ROW_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd4;

	// register reset values
	localparam logic [WIDTH_REG_W-1:0] RST_IMAGE_WIDTH = 13'd640;
	localparam logic [ROW_W-1:0] RST_IMAGE_HEIGHT = 16'd480;
	localparam mark_t RST_LEVEL_FIRST = 24'sd0;
	localparam mark_t RST_LEVEL_STEP = 24'sd256;

	// saturation bounds of a level
	localparam mark_t MARK_MAX = 24'sh7FFFFF;
	localparam mark_t MARK_MIN = 24'sh800000;

	// accumulator wide enough for first + k*step, k below 256
	localparam int LVL_ACC_W = 34;

	// marks of one finished cell and which of its pixels leave the block
	// emit bit 0: top-left, 1: top-right, 2: bottom-left, 3: bottom-right
	typedef struct packed {
		logic [3:0] emit;
		mark_t [3:0] marks;
	} cell_res_t;

endpackage

/* rtl/core/ilm_levels.sv */
// Level generator: registers first + k*step, saturated to Q16.8, per level.
// Depends on ilm_pkg.
`timescale 1ns / 1ps

module ilm_levels #(
	parameter int MAX_LEVELS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  ilm_pkg::mark_t level_first,
	input  ilm_pkg::mark_t level_step,
	input  logic [$clog2(MAX_LEVELS+1)-1:0] level_count,
	output ilm_pkg::mark_t levels [MAX_LEVELS],
	output logic [MAX_LEVELS-1:0] active
);
	import ilm_pkg::*;

	logic signed [LVL_ACC_W-1:0] acc [MAX_LEVELS];
	mark_t lvl_d [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] act_d;
	logic [MAX_LEVELS-1:0] act_q;
	mark_t lvl_q [MAX_LEVELS];

	// one constant multiple of the step per level, then saturate
	always_comb begin
		for (int k = 0; k < MAX_LEVELS; k++) begin
			acc[k] = LVL_ACC_W'(level_first) + LVL_ACC_W'(k) * LVL_ACC_W'(level_step);
			if (acc[k] > LVL_ACC_W'(MARK_MAX)) begin
				lvl_d[k] = MARK_MAX;
			end else if (acc[k] < LVL_ACC_W'(MARK_MIN)) begin
				lvl_d[k] = MARK_MIN;
			end else begin
				lvl_d[k] = acc[k][MARK_W-1:0];
			end
			act_d[k] = 32'(k) < 32'(level_count);
		end
	end

	// level values carry no reset
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LEVELS; k++) begin
			lvl_q[k] <= lvl_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else begin
			act_q <= act_d;
		end
	end

	assign levels = lvl_q;
	assign active = act_q;

endmodule

/* rtl/core/ilm_line_ram.sv */
// Line memory: previous-row pixel and pending mark per column, one read and
// one write port, registered read with write forwarding, fill count.
// Depends on ilm_pkg.
`timescale 1ns / 1ps

module ilm_line_ram #(
	parameter int DEPTH = 4096,
	parameter int DW = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data,
	output logic rd_fresh
);
	import ilm_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;
	logic rd_fresh_q;
	logic [AW:0] fill_q;
	logic fwd;

	assign fwd = wr_en && (wr_addr == rd_addr);

	// storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, same-address write forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= fwd ? wr_data : mem_q[rd_addr];
		end
	end

	// the fill count is one above the highest entry written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_fresh_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_fresh_q <= fwd || ({1'b0, rd_addr} < fill_q);
			end
			if (wr_en && ({1'b0, wr_addr} >= fill_q)) begin
				fill_q <= {1'b0, wr_addr} + (AW+1)'(1);
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_fresh = rd_fresh_q;

endmodule

/* rtl/core/ilm_outq.sv */
// Output stage: holds the finished pixels of one cell and hands them out
// one transaction at a time in raster order. Depends on ilm_pkg.
`timescale 1ns / 1ps

module ilm_outq #(
	parameter int AW = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic free,
	input  ilm_pkg::cell_res_t res,
	input  logic [AW-1:0] col_lo,
	input  logic [AW-1:0] col_hi,
	input  logic [ilm_pkg::ROW_W-1:0] row_lo,
	input  logic [ilm_pkg::ROW_W-1:0] row_hi,
	output logic out_valid,
	input  logic out_ready,
	output logic [AW-1:0] out_col,
	output logic [ilm_pkg::ROW_W-1:0] out_row,
	output ilm_pkg::mark_t level_mark,
	output logic image_end
);
	import ilm_pkg::*;

	logic [3:0] mask_q;
	mark_t [3:0] marks_q;
	logic [AW-1:0] col_lo_q, col_hi_q;
	logic [ROW_W-1:0] row_lo_q, row_hi_q;
	logic [3:0] low_bit;
	logic last_one;

	assign low_bit = mask_q & (~mask_q + 4'd1);
	assign last_one = (mask_q & (mask_q - 4'd1)) == 4'd0;
	assign out_valid = mask_q != 4'd0;
	assign free = !out_valid || (out_ready && last_one);

	// select the lowest pending pixel
	always_comb begin
		out_col = col_lo_q;
		out_row = row_lo_q;
		level_mark = marks_q[0];
		image_end = 1'b0;
		if (low_bit[1]) begin
			out_col = col_hi_q;
			level_mark = marks_q[1];
		end else if (low_bit[2]) begin
			out_row = row_hi_q;
			level_mark = marks_q[2];
		end else if (low_bit[3]) begin
			out_col = col_hi_q;
			out_row = row_hi_q;
			level_mark = marks_q[3];
			image_end = 1'b1;
		end
	end

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (push && free) begin
			mask_q <= res.emit;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_q & ~low_bit;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (push && free) begin
			marks_q <= res.marks;
			col_lo_q <= col_lo;
			col_hi_q <= col_hi;
			row_lo_q <= row_lo;
			row_hi_q <= row_hi;
		end
	end

endmodule

/* rtl/core/isoline_level_marker_top.sv */
// Isoline level marker: 2x2 cell level test over a raster pixel stream.
// The first result of a pixel passes the stage 1 registers, then the output stage registers.
// Throughput: one pixel per cycle while out_ready is high; a pixel that finishes a cell waits
//   while the output stage still holds more than one result of the previous pixel.
// The line memory gives one read and one write per cycle; the last-column write
//   is deferred to the following column-0 pixel.
// Reset (arst_n low, asynchronous): counters, marks and configuration registers to defaults.
`timescale 1ns / 1ps

module isoline_level_marker_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_LEVELS = 16,
	parameter int PIXEL_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ilm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ilm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [PIXEL_BITS-1:0] pixel_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0] out_col,
	output logic [ilm_pkg::ROW_W-1:0] out_row,
	output ilm_pkg::mark_t level_mark,
	output logic image_end
);
	import ilm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WCW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;
	localparam int CNT_W = $clog2(MAX_LEVELS + 1);
	localparam int CMPW = (PIXEL_BITS + FRAC_BITS > MARK_W) ? PIXEL_BITS + FRAC_BITS : MARK_W;
	localparam int DW = PIXEL_BITS + MARK_W;

	// configuration registers
	logic [WIDTH_REG_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	mark_t first_q, step_q;
	logic [4:0] count_q;
	logic [CNT_W-1:0] count_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			first_q <= RST_LEVEL_FIRST;
			step_q <= RST_LEVEL_STEP;
			count_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				REG_LEVEL_FIRST: first_q <= cfg_data[MARK_W-1:0];
				REG_LEVEL_STEP: step_q <= cfg_data[MARK_W-1:0];
				REG_LEVEL_COUNT: count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign count_eff = (32'(count_q) > MAX_LEVELS) ? CNT_W'(MAX_LEVELS) : CNT_W'(count_q);

	// level values
	mark_t levels [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] active;

	ilm_levels #(.MAX_LEVELS(MAX_LEVELS)) u_levels (
		.clk(clk),
		.arst_n(arst_n),
		.level_first(first_q),
		.level_step(step_q),
		.level_count(count_eff),
		.levels(levels),
		.active(active)
	);

	// effective geometry and position of the incoming pixel
	logic [AW-1:0] col_q, x_eff;
	logic [ROW_W-1:0] row_q, h_eff;
	logic [WCW-1:0] w_eff;
	logic last_col, last_row, in_acc;

	always_comb begin
		if (WCW'(width_q) < WCW'(2)) begin
			w_eff = WCW'(2);
		end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(width_q);
		end
		h_eff = (height_q < ROW_W'(2)) ? ROW_W'(2) : height_q;
		x_eff = (32'(col_q) > MAX_WIDTH - 1) ? AW'(MAX_WIDTH - 1) : col_q;
	end

	assign last_col = WCW'(x_eff) >= (w_eff - WCW'(1));
	assign last_row = row_q >= (h_eff - ROW_W'(1));
	assign in_acc = in_valid && in_ready;

	// stage 1 registers
	logic vld_s1, lc_s1, lr_s1;
	logic signed [PIXEL_BITS-1:0] cur_s1, lp_s1;
	logic [AW-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;
	logic signed [PIXEL_BITS-1:0] left_pixel_q, a_prev_q;
	mark_t left_mark_q, m_prev_q;
	logic s1_adv, q_free;
	cell_res_t res;

	assign s1_adv = vld_s1 && ((res.emit == 4'd0) || q_free);
	assign in_ready = !vld_s1 || s1_adv;

	// raster counters and left pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_pixel_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				left_pixel_q <= pixel_value;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= x_eff + AW'(1);
				end
			end
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1 <= pixel_value;
			lp_s1 <= left_pixel_q;
			x_s1 <= x_eff;
			y_s1 <= row_q;
			lc_s1 <= last_col;
			lr_s1 <= last_row;
		end
	end

	// line memory access
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data, rd_data;
	logic rd_fresh;
	logic tail_vld_q;
	logic [AW-1:0] tail_addr_q;
	logic [DW-1:0] tail_data_q;
	logic x0, y0;
	logic signed [PIXEL_BITS-1:0] rd_pix;
	mark_t rd_mark, pend_rd;
	mark_t fm [4];

	ilm_line_ram #(.DEPTH(MAX_WIDTH), .DW(DW)) u_line_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_acc),
		.rd_addr(x_eff),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data),
		.rd_fresh(rd_fresh)
	);

	assign x0 = x_s1 == '0;
	assign y0 = y_s1 == '0;
	assign rd_pix = rd_data[DW-1:MARK_W];
	assign rd_mark = rd_data[MARK_W-1:0];
	assign pend_rd = rd_fresh ? rd_mark : '0;

	// write back the left column of the cell, or the deferred last column
	assign wr_en = s1_adv && (!x0 || tail_vld_q);
	assign wr_addr = x0 ? tail_addr_q : x_s1 - AW'(1);
	assign wr_data = x0 ? tail_data_q : {lp_s1, fm[2]};

	// cell level test: later levels overwrite earlier marks
	always_comb begin
		logic signed [CMPW-1:0] p [4];
		logic signed [CMPW-1:0] lv;
		logic [3:0] ge;
		logic any;
		p[0] = CMPW'(a_prev_q) <<< FRAC_BITS;
		p[1] = CMPW'(rd_pix) <<< FRAC_BITS;
		p[2] = CMPW'(lp_s1) <<< FRAC_BITS;
		p[3] = CMPW'(cur_s1) <<< FRAC_BITS;
		fm[0] = m_prev_q;
		fm[1] = y0 ? '0 : pend_rd;
		fm[2] = left_mark_q;
		fm[3] = '0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			lv = CMPW'(levels[k]);
			for (int j = 0; j < 4; j++) begin
				ge[j] = p[j] >= lv;
			end
			any = active[k] && !y0 && (ge != 4'd0);
			for (int j = 0; j < 4; j++) begin
				if (any && !ge[j]) begin
					fm[j] = levels[k];
				end
			end
		end
	end

	// results leaving with this cell
	always_comb begin
		res.marks = {fm[3], fm[2], fm[1], fm[0]};
		if (x0 || y0) begin
			res.emit = 4'd0;
		end else begin
			res.emit = {lc_s1 && lr_s1, lr_s1, lc_s1, 1'b1};
		end
	end

	// carried column state and deferred write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mark_q <= '0;
			m_prev_q <= '0;
			a_prev_q <= '0;
			tail_vld_q <= 1'b0;
		end else if (s1_adv) begin
			left_mark_q <= x0 ? '0 : fm[3];
			m_prev_q <= x0 ? pend_rd : fm[1];
			a_prev_q <= rd_pix;
			if (x0) begin
				tail_vld_q <= 1'b0;
			end else if (lc_s1) begin
				tail_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && !x0 && lc_s1) begin
			tail_addr_q <= x_s1;
			tail_data_q <= {cur_s1, fm[3]};
		end
	end

	// output stage
	ilm_outq #(.AW(AW)) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(s1_adv && (res.emit != 4'd0)),
		.free(q_free),
		.res(res),
		.col_lo(x_s1 - AW'(1)),
		.col_hi(x_s1),
		.row_lo(y_s1 - ROW_W'(1)),
		.row_hi(y_s1),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_col(out_col),
		.out_row(out_row),
		.level_mark(level_mark),
		.image_end(image_end)
	);

endmodule

/* rtl/core/ilm_checker.sv */
// Port-level checks for the isoline level marker, bound to the top level.
// Depends on ilm_pkg and isoline_level_marker_top.
`timescale 1ns / 1ps

module ilm_checker #(
	parameter int AW = 12
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [AW-1:0] out_col,
	input logic [ilm_pkg::ROW_W-1:0] out_row,
	input ilm_pkg::mark_t level_mark,
	input logic image_end
);
	import ilm_pkg::*;

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
			&& $stable(level_mark) && $stable(image_end))
		else $error("result changed while stalled");

	// the image end is the bottom-right pixel, never on row or column zero
	a_end_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> out_col != '0 && out_row != '0)
		else $error("image end outside the last cell");

	// the result after an image end opens the next image at the origin
	a_next_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && image_end |=> !out_valid
			|| (out_col == '0 && out_row == '0))
		else $error("next image does not start at the origin");

	// nothing is shown right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind isoline_level_marker_top ilm_checker #(.AW($clog2(MAX_WIDTH))) u_ilm_checker (.*);
